// File: src/lsi_pkg.sv
// Package for the line segment intersection block: widths, status codes.
package lsi_pkg;

  localparam int CB   = 16;          // coordinate width
  localparam int FB   = 8;           // fraction bits of the hit point
  localparam int QW   = 32;          // result coordinate width
  localparam int DW   = CB + 1;      // coordinate difference width
  localparam int PW   = 2 * DW;      // product of two differences
  localparam int DETW = PW + 1;      // determinant and parameter numerators
  localparam int NW   = DETW + DW + 1;  // base*det + tn*dir
  localparam int NSW  = NW + FB;     // numerator magnitude after the fraction shift
  localparam int CMPW = (NSW > DETW + QW) ? NSW : DETW + QW;
  localparam int DIV_LAT = QW + 1;   // divider register stages
  localparam int FRONT_LAT = 6;      // stages before the divider

  localparam int OP_FIRST_SEG  = 0;
  localparam int OP_SECOND_SEG = 1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

endpackage

// File: src/lsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module lsi_div import lsi_pkg::*; (
  input  logic            clk,
  input  logic [NSW-1:0]  num,
  input  logic [DETW-1:0] den,
  input  logic            neg,
  output logic [QW-1:0]   quo,
  output logic            big,
  output logic            quo_neg
);

  logic [DETW-1:0] r_r   [0:QW];
  logic [QW-1:0]   lo_r  [0:QW];
  logic [QW-1:0]   q_r   [0:QW];
  logic [DETW-1:0] den_r [0:QW];
  logic            neg_r [0:QW];
  logic            big_r [0:QW];

  logic            big_nxt;

  // A quotient of 2^QW or more saturates anyway, so only QW bits are developed.
  assign big_nxt = CMPW'(num) >= CMPW'({den, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    r_r[0]   <= DETW'(num >> QW);
    lo_r[0]  <= num[QW-1:0];
    q_r[0]   <= '0;
    den_r[0] <= den;
    neg_r[0] <= neg;
    big_r[0] <= big_nxt;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DETW:0]   t;
    logic            ge;
    logic [DETW-1:0] r_nxt;

    assign t     = {r_r[k], lo_r[k][QW-1-k]};
    assign ge    = t >= {1'b0, den_r[k]};
    assign r_nxt = ge ? DETW'(t - {1'b0, den_r[k]}) : DETW'(t);

    always_ff @(posedge clk) begin
      r_r[k+1]   <= r_nxt;
      lo_r[k+1]  <= lo_r[k];
      q_r[k+1]   <= {q_r[k][QW-2:0], ge};
      den_r[k+1] <= den_r[k];
      neg_r[k+1] <= neg_r[k];
      big_r[k+1] <= big_r[k];
    end
  end

  assign quo     = q_r[QW];
  assign big     = big_r[QW];
  assign quo_neg = neg_r[QW];

endmodule

// File: src/line_segment_intersection.sv
// Top level of the pipelined two-dimensional line and segment intersection block.
// The pipeline holds 40 register stages.
// Throughput: one word per cycle; busy is always low and the receiver cannot stall.
// Six front stages, the divider input stage, 32 quotient stages and the output stage.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module line_segment_intersection import lsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic signed [CB-1:0] in_first_x1,
  input  logic signed [CB-1:0] in_first_y1,
  input  logic signed [CB-1:0] in_first_x2,
  input  logic signed [CB-1:0] in_first_y2,
  input  logic signed [CB-1:0] in_second_x1,
  input  logic signed [CB-1:0] in_second_y1,
  input  logic signed [CB-1:0] in_second_x2,
  input  logic signed [CB-1:0] in_second_y2,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic signed [QW-1:0] out_hit_x,
  output logic signed [QW-1:0] out_hit_y,
  output logic                 out_clipped
);

  // Every stage takes a new word each cycle, so the block never pushes back.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: direction vectors d1, d2 and the offset between the start points.
  logic                 v1_r;
  logic [1:0]           op1_r;
  logic signed [CB-1:0] p1x1_r, p1y1_r;
  logic signed [DW-1:0] d1x1_r, d1y1_r, d2x1_r, d2y1_r, dpx1_r, dpy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    op1_r  <= in_op;
    p1x1_r <= in_first_x1;
    p1y1_r <= in_first_y1;
    d1x1_r <= DW'(in_first_x2) - DW'(in_first_x1);
    d1y1_r <= DW'(in_first_y2) - DW'(in_first_y1);
    d2x1_r <= DW'(in_second_x2) - DW'(in_second_x1);
    d2y1_r <= DW'(in_second_y2) - DW'(in_second_y1);
    dpx1_r <= DW'(in_second_x1) - DW'(in_first_x1);
    dpy1_r <= DW'(in_second_y1) - DW'(in_first_y1);
  end

  // Stage 2: the six cross products that make up det, tn and un.
  logic                 v2_r;
  logic [1:0]           op2_r;
  logic signed [CB-1:0] p1x2_r, p1y2_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r;
  logic signed [PW-1:0] ma_r, mb_r, mc_r, md_r, me_r, mf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r  <= op1_r;
    p1x2_r <= p1x1_r;
    p1y2_r <= p1y1_r;
    d1x2_r <= d1x1_r;
    d1y2_r <= d1y1_r;
    ma_r   <= PW'(d1x1_r) * PW'(d2y1_r);
    mb_r   <= PW'(d2x1_r) * PW'(d1y1_r);
    mc_r   <= PW'(d2y1_r) * PW'(dpx1_r);
    md_r   <= PW'(d2x1_r) * PW'(dpy1_r);
    me_r   <= PW'(d1y1_r) * PW'(dpx1_r);
    mf_r   <= PW'(d1x1_r) * PW'(dpy1_r);
  end

  // Stage 3: determinant and the numerators of both intersection parameters.
  logic                   v3_r;
  logic [1:0]             op3_r;
  logic signed [CB-1:0]   p1x3_r, p1y3_r;
  logic signed [DW-1:0]   d1x3_r, d1y3_r;
  logic signed [DETW-1:0] det3_r, tn3_r, un3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op3_r  <= op2_r;
    p1x3_r <= p1x2_r;
    p1y3_r <= p1y2_r;
    d1x3_r <= d1x2_r;
    d1y3_r <= d1y2_r;
    det3_r <= DETW'(ma_r) - DETW'(mb_r);
    tn3_r  <= DETW'(mc_r) - DETW'(md_r);
    un3_r  <= DETW'(me_r) - DETW'(mf_r);
  end

  // Stage 4: classify the word and form p1*det and tn*d1 for each axis.
  // A parameter lies in 0..1 when its numerator sits between zero and det,
  // on whichever side of zero det lies; exact endpoints count as inside.
  logic    t_in, u_in;
  status_t status4_nxt;

  assign t_in = (det3_r > 0) ? (tn3_r >= 0 && tn3_r <= det3_r)
                             : (tn3_r <= 0 && tn3_r >= det3_r);
  assign u_in = (det3_r > 0) ? (un3_r >= 0 && un3_r <= det3_r)
                             : (un3_r <= 0 && un3_r >= det3_r);

  always_comb begin
    if (det3_r == '0) begin
      status4_nxt = ST_PARALLEL;
    end else if ((op3_r[OP_FIRST_SEG] && !t_in) || (op3_r[OP_SECOND_SEG] && !u_in)) begin
      status4_nxt = ST_OUTSIDE;
    end else begin
      status4_nxt = ST_HIT;
    end
  end

  logic                   v4_r;
  status_t                status4_r;
  logic signed [DETW-1:0] det4_r;
  logic signed [NW-1:0]   bx4_r, by4_r, tx4_r, ty4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    status4_r <= status4_nxt;
    det4_r    <= det3_r;
    bx4_r     <= NW'(p1x3_r) * NW'(det3_r);
    by4_r     <= NW'(p1y3_r) * NW'(det3_r);
    tx4_r     <= NW'(tn3_r) * NW'(d1x3_r);
    ty4_r     <= NW'(tn3_r) * NW'(d1y3_r);
  end

  // Stage 5: numerators of the hit coordinates, scaled by det.
  logic                   v5_r;
  status_t                status5_r;
  logic signed [DETW-1:0] det5_r;
  logic signed [NW-1:0]   nx5_r, ny5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    status5_r <= status4_r;
    det5_r    <= det4_r;
    nx5_r     <= bx4_r + tx4_r;
    ny5_r     <= by4_r + ty4_r;
  end

  // Stage 6: split into sign and magnitude and apply the fraction shift.
  logic [NW-1:0]   magx, magy;
  logic            negx6_nxt, negy6_nxt;
  logic [DETW-1:0] den6_nxt;

  assign magx      = nx5_r[NW-1] ? NW'(-nx5_r) : NW'(nx5_r);
  assign magy      = ny5_r[NW-1] ? NW'(-ny5_r) : NW'(ny5_r);
  assign negx6_nxt = nx5_r[NW-1] ^ det5_r[DETW-1];
  assign negy6_nxt = ny5_r[NW-1] ^ det5_r[DETW-1];
  assign den6_nxt  = det5_r[DETW-1] ? DETW'(-det5_r) : DETW'(det5_r);

  logic            v6_r;
  status_t         status6_r;
  logic [NSW-1:0]  numx6_r, numy6_r;
  logic [DETW-1:0] den6_r;
  logic            negx6_r, negy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    status6_r <= status5_r;
    numx6_r   <= NSW'(magx) << FB;
    numy6_r   <= NSW'(magy) << FB;
    den6_r    <= den6_nxt;
    negx6_r   <= negx6_nxt;
    negy6_r   <= negy6_nxt;
  end

  // Dividers: one per axis; valid and status ride alongside in a shift line.
  logic [QW-1:0] qx, qy;
  logic          bigx, bigy, qnegx, qnegy;

  lsi_div u_div_x (
    .clk     (clk),
    .num     (numx6_r),
    .den     (den6_r),
    .neg     (negx6_r),
    .quo     (qx),
    .big     (bigx),
    .quo_neg (qnegx)
  );

  lsi_div u_div_y (
    .clk     (clk),
    .num     (numy6_r),
    .den     (den6_r),
    .neg     (negy6_r),
    .quo     (qy),
    .big     (bigy),
    .quo_neg (qnegy)
  );

  logic    vsh_r  [0:DIV_LAT-1];
  status_t stsh_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vsh_r[i] <= 1'b0;
      end
    end else begin
      vsh_r[0] <= v6_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vsh_r[i] <= vsh_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    stsh_r[0] <= status6_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      stsh_r[i] <= stsh_r[i-1];
    end
  end

  // Output stage: saturate to the signed range, restore the sign, and force
  // the coordinates to zero when there is no hit.
  logic [QW-1:0] limx, limy, valx, valy;
  logic          clipx, clipy, hit;

  assign limx  = qnegx ? QW'(1) << (QW - 1) : (QW'(1) << (QW - 1)) - QW'(1);
  assign limy  = qnegy ? QW'(1) << (QW - 1) : (QW'(1) << (QW - 1)) - QW'(1);
  assign clipx = bigx || (qx > limx);
  assign clipy = bigy || (qy > limy);
  assign valx  = clipx ? limx : qx;
  assign valy  = clipy ? limy : qy;
  assign hit   = (stsh_r[DIV_LAT-1] == ST_HIT);

  logic          out_valid_r;
  status_t       out_status_r;
  logic [QW-1:0] out_hit_x_r, out_hit_y_r;
  logic          out_clipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vsh_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= stsh_r[DIV_LAT-1];
    out_hit_x_r   <= hit ? (qnegx ? QW'(-valx) : valx) : '0;
    out_hit_y_r   <= hit ? (qnegy ? QW'(-valy) : valy) : '0;
    out_clipped_r <= hit && (clipx || clipy);
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_hit_x   = out_hit_x_r;
  assign out_hit_y   = out_hit_y_r;
  assign out_clipped = out_clipped_r;

  // A word that is not a hit carries all-zero coordinates and no clip flag.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_HIT) |-> (out_hit_x == '0 && out_hit_y == '0 && !out_clipped))
    else $error("miss result carries nonzero coordinates");

  // A clipped result has at least one coordinate on a rail of the range.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_hit_x == {1'b0, {(QW-1){1'b1}}} || out_hit_x == {1'b1, {(QW-1){1'b0}}} ||
       out_hit_y == {1'b0, {(QW-1){1'b1}}} || out_hit_y == {1'b1, {(QW-1){1'b0}}}))
    else $error("clipped result not saturated");

  // The result strobe follows the tail of the divider side line in the next cycle.
  a_valid_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vsh_r[DIV_LAT-1]))
    else $error("result strobe without a word in the pipeline");

endmodule
